// File: rtl/sss_pkg.sv
package sss_pkg;

  localparam int NUM_AXES        = 3;
  localparam int CMD_W           = 17;
  localparam int STEP_W          = 15;
  localparam int THR_W           = 10;
  localparam int CFG_DATA_W      = 15;
  localparam int CFG_INDEX_W     = 2;
  localparam int QBITS           = 15;
  localparam int CNT_W           = 4;
  localparam int ANGLE_WIDTH_DEF = 18;
  localparam int TDATA_W         = 56;
  localparam int PAD_W           = TDATA_W - NUM_AXES * CMD_W;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(706);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(5);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_LEFT  = 2'd0,
    REG_STEP_RIGHT = 2'd1,
    REG_STEP_BASE  = 2'd2,
    REG_DONE_THR   = 2'd3
  } cfg_reg_t;

  // per-tick sequencing strobes shared by all lanes
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic commit;
  } lane_ctl_t;

endpackage

// File: rtl/sss_lane.sv
module sss_lane
  import sss_pkg::*;
#(
  parameter int ANGLE_W = ANGLE_WIDTH_DEF,
  parameter int DIST_W  = ((ANGLE_WIDTH_DEF > CMD_W) ? ANGLE_WIDTH_DEF : CMD_W) + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lane_ctl_t               ctl,
  input  logic signed [CMD_W-1:0] cmd_in,
  input  logic [STEP_W-1:0]       full,
  input  logic [THR_W-1:0]        thresh,
  input  logic [DIST_W-1:0]       dmax,
  output logic [DIST_W-1:0]       span,
  output logic                    near,
  output logic [CMD_W-1:0]        pos
);

  localparam int PROD_W = STEP_W + DIST_W;

  logic signed [CMD_W-1:0]   cmd_r;
  logic signed [ANGLE_W-1:0] angle;
  logic signed [DIST_W-1:0]  cmd_x;
  logic signed [DIST_W-1:0]  ang_x;
  logic signed [DIST_W-1:0]  diff;
  logic signed [DIST_W-1:0]  lim_x;
  logic signed [DIST_W-1:0]  move_val;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         rem;
  logic [PROD_W-1:0]         dvsr;
  logic [STEP_W-1:0]         q;

  assign cmd_x = {{(DIST_W-CMD_W){cmd_r[CMD_W-1]}}, cmd_r};
  assign ang_x = {{(DIST_W-ANGLE_W){angle[ANGLE_W-1]}}, angle};
  assign diff  = cmd_x - ang_x;
  assign span  = diff[DIST_W-1] ? $unsigned(-diff) : $unsigned(diff);
  assign near  = span < DIST_W'(thresh);
  assign pos   = ang_x[CMD_W-1:0];

  assign prod  = PROD_W'(full) * PROD_W'(span);
  assign lim_x = {{(DIST_W-STEP_W){1'b0}}, q};

  // a zero distance lands on the command whatever the limit, so dmax of zero needs no case
  always_comb begin
    if (diff > lim_x) begin
      move_val = ang_x + lim_x;
    end else if (diff < -lim_x) begin
      move_val = ang_x - lim_x;
    end else begin
      move_val = cmd_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
    end else if (ctl.commit) begin
      angle <= move_val[ANGLE_W-1:0];
    end
  end

  // restoring division, one quotient bit a cycle, quotient never exceeds full while dmax is nonzero
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd_in;
    end
    if (ctl.mul) begin
      rem  <= prod;
      dvsr <= PROD_W'(dmax) << (QBITS - 1);
      q    <= '0;
    end else if (ctl.step) begin
      if (rem >= dvsr) begin
        rem <= rem - dvsr;
        q   <= {q[STEP_W-2:0], 1'b1};
      end else begin
        q   <= {q[STEP_W-2:0], 1'b0};
      end
      dvsr <= dvsr >> 1;
    end
  end

endmodule

// File: rtl/sss_merge.sv
module sss_merge
  import sss_pkg::*;
#(
  parameter int DIST_W = ((ANGLE_WIDTH_DEF > CMD_W) ? ANGLE_WIDTH_DEF : CMD_W) + 1
) (
  input  logic              clk,
  input  logic              capture,
  input  logic [DIST_W-1:0] span [NUM_AXES],
  input  logic [NUM_AXES-1:0] near,
  output logic [DIST_W-1:0] dmax,
  output logic              all_near
);

  logic [DIST_W-1:0] max_c;

  always_comb begin
    max_c = span[0];
    for (int i = 1; i < NUM_AXES; i++) begin
      if (span[i] > max_c) begin
        max_c = span[i];
      end
    end
  end

  assign all_near = &near;

  always_ff @(posedge clk) begin
    if (capture) begin
      dmax <= max_c;
    end
  end

endmodule

// File: rtl/synchronized_servo_stepper.sv
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  tdata: cmd_left, cmd_right, cmd_base; tuser: reachable
// m_*       out        m_tvalid / m_tready  tdata: pos_left, pos_right, pos_base; tuser: arrived
// cfg_*     in         cfg_we               cfg_index selects register, cfg_data value
//
// an accepted item passes through these steps in order before its result is loaded:
// distance max, multiply, then the 15-step radix-2 divider in each lane, one quotient
// bit a cycle, commit and output load
// the next item is accepted the cycle after the result is loaded; a stalled output
// holds the following item in its output load cycle until the register frees up
// reset is synchronous: angles go to zero, step registers to 706, threshold to 5
module synchronized_servo_stepper
  import sss_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // cmd_left, cmd_right, cmd_base, zero pad
  input  logic                   s_tuser,   // reachable
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_W-1:0]     m_tdata,   // pos_left, pos_right, pos_base, zero pad
  output logic                   m_tuser,   // arrived
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIST_W = ((ANGLE_WIDTH > CMD_W) ? ANGLE_WIDTH : CMD_W) + 1;

  typedef enum logic [2:0] {S_IDLE, S_MAX, S_MUL, S_DIV, S_FIN, S_OUT} state_t;

  state_t              state;
  logic [CNT_W-1:0]    div_cnt;
  logic                reach_r;
  logic [STEP_W-1:0]   max_step [NUM_AXES];
  logic [THR_W-1:0]    done_threshold;
  lane_ctl_t           ctl;
  logic [DIST_W-1:0]   span [NUM_AXES];
  logic [NUM_AXES-1:0] near;
  logic [CMD_W-1:0]    pos [NUM_AXES];
  logic [DIST_W-1:0]   dmax;
  logic                all_near;
  logic                out_free;
  logic                s_fire;

  assign s_tready = (state == S_IDLE) && !rst;
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign ctl.load   = s_fire;
  assign ctl.mul    = (state == S_MUL);
  assign ctl.step   = (state == S_DIV);
  assign ctl.commit = (state == S_FIN) && reach_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step[0]    <= STEP_RESET;
      max_step[1]    <= STEP_RESET;
      max_step[2]    <= STEP_RESET;
      done_threshold <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_LEFT:  max_step[0]    <= cfg_data[STEP_W-1:0];
        REG_STEP_RIGHT: max_step[1]    <= cfg_data[STEP_W-1:0];
        REG_STEP_BASE:  max_step[2]    <= cfg_data[STEP_W-1:0];
        REG_DONE_THR:   done_threshold <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    sss_lane #(
      .ANGLE_W(ANGLE_WIDTH),
      .DIST_W (DIST_W)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .cmd_in(s_tdata[i*CMD_W +: CMD_W]),
      .full  (max_step[i]),
      .thresh(done_threshold),
      .dmax  (dmax),
      .span  (span[i]),
      .near  (near[i]),
      .pos   (pos[i])
    );
  end

  sss_merge #(
    .DIST_W(DIST_W)
  ) u_merge (
    .clk     (clk),
    .capture (state == S_MAX),
    .span    (span),
    .near    (near),
    .dmax    (dmax),
    .all_near(all_near)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      div_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            reach_r <= s_tuser;
            state   <= S_MAX;
          end
        end
        S_MAX: state <= S_MUL;
        S_MUL: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(QBITS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          // near flags now compare the committed angles with the commands
          if (out_free) begin
            m_tdata  <= {{PAD_W{1'b0}}, pos[2], pos[1], pos[0]};
            m_tuser  <= reach_r && all_near;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_unreach_not_arrived: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free && !reach_r) |=> !m_tuser)
    else $error("arrived raised on an unreachable item");

  a_unreach_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !reach_r) |=>
      ($stable(pos[0]) && $stable(pos[1]) && $stable(pos[2])))
    else $error("angles moved on an unreachable item");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt < CNT_W'(QBITS)))
    else $error("divider step count overran");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (!s_tready && !ctl.commit))
    else $error("second item taken while one is at work");

endmodule
